// ===== sv/dgm_pkg.sv =====
// shared constants and types for the duotone gradient map with mask
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package dgm_pkg;

  localparam int unsigned ChanW  = 8;
  localparam int unsigned ColorW = 24;
  localparam int unsigned SumW   = 10;
  localparam int unsigned NumW   = 18;

  localparam logic [SumW-1:0] FullScale = 10'd765;

  // floor(n / 765) == (n * DivMul) >> DivShift for every n below 765 * 256
  localparam int unsigned    DivMulW  = 19;
  localparam int unsigned    DivShift = 28;
  localparam logic [DivMulW-1:0] DivMul = 19'd350897;

  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 24;

  typedef enum logic [CfgIdxW-1:0] {
    CfgBgLow     = 3'd0,
    CfgBgHigh    = 3'd1,
    CfgMaskLow   = 3'd2,
    CfgMaskHigh  = 3'd3,
    CfgInvert    = 3'd4,
    CfgThreshold = 3'd5
  } cfg_idx_e;

endpackage

`default_nettype wire

// ===== sv/duotone_gradient_map_with_mask_unit.sv =====
// duotone gradient map with mask: top level, config registers and pipeline
// depends on dgm_pkg and dgm_blend
// out_valid_o pulses once an item has passed all four register stages listed below
// throughput: one item per cycle, busy_o is never raised; four register stages
// (input, gradient select, products, quotient) each take a new item every cycle
// results cannot be stalled; reset clears the pipeline valids and loads the
// register defaults
`timescale 1ns / 1ps
`default_nettype none

module duotone_gradient_map_with_mask_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic [dgm_pkg::ChanW-1:0]     back_red_i,
  input  logic [dgm_pkg::ChanW-1:0]     back_green_i,
  input  logic [dgm_pkg::ChanW-1:0]     back_blue_i,
  input  logic [dgm_pkg::ChanW-1:0]     mask_red_i,
  input  logic [dgm_pkg::ChanW-1:0]     mask_green_i,
  input  logic [dgm_pkg::ChanW-1:0]     mask_blue_i,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [dgm_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [dgm_pkg::CfgDataW-1:0]  cfg_data_i,
  output logic                          out_valid_o,
  output logic [dgm_pkg::ChanW-1:0]     out_red_o,
  output logic [dgm_pkg::ChanW-1:0]     out_green_o,
  output logic [dgm_pkg::ChanW-1:0]     out_blue_o,
  output logic                          inside_mask_o
);
  import dgm_pkg::*;

  // configuration registers
  logic [ColorW-1:0] bg_low_q, bg_high_q, mask_low_q, mask_high_q;
  logic              invert_q;
  logic [ChanW-1:0]  thresh_q;

  assign cfg_ready_o = 1'b1;
  assign busy_o      = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bg_low_q    <= 24'h000000;
      bg_high_q   <= 24'hFFFFFF;
      mask_low_q  <= 24'h000000;
      mask_high_q <= 24'hFFFFFF;
      invert_q    <= 1'b1;
      thresh_q    <= 8'd50;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CfgBgLow:     bg_low_q    <= cfg_data_i;
        CfgBgHigh:    bg_high_q   <= cfg_data_i;
        CfgMaskLow:   mask_low_q  <= cfg_data_i;
        CfgMaskHigh:  mask_high_q <= cfg_data_i;
        CfgInvert:    invert_q    <= cfg_data_i[0];
        CfgThreshold: thresh_q    <= cfg_data_i[ChanW-1:0];
        default: ;
      endcase
    end
  end

  // input register
  logic             in_vld_q;
  logic [ChanW-1:0] br_q, bgn_q, bb_q, mr_q, mg_q, mb_q;
  logic             accept;

  assign accept = start_i && !busy_o;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      br_q  <= back_red_i;
      bgn_q <= back_green_i;
      bb_q  <= back_blue_i;
      mr_q  <= mask_red_i;
      mg_q  <= mask_green_i;
      mb_q  <= mask_blue_i;
    end
  end

  // gradient select stage
  logic [SumW-1:0]   back_sum, mask_sum, thresh3, mix_d;
  logic              inside_d;
  logic [ColorW-1:0] low_d, high_d;

  always_comb begin
    back_sum = SumW'(br_q) + SumW'(bgn_q) + SumW'(bb_q);
    mask_sum = SumW'(mr_q) + SumW'(mg_q) + SumW'(mb_q);
    thresh3  = SumW'(thresh_q) + SumW'({thresh_q, 1'b0});
    inside_d = mask_sum > thresh3;
    low_d    = inside_d ? mask_low_q : bg_low_q;
    high_d   = inside_d ? mask_high_q : bg_high_q;
    mix_d    = (inside_d && invert_q) ? (FullScale - back_sum) : back_sum;
  end

  logic              sel_vld_q;
  logic [ColorW-1:0] low_q, high_q;
  logic [SumW-1:0]   mix_q;
  logic              inside_q;

  always_ff @(posedge clk_i) begin
    low_q    <= low_d;
    high_q   <= high_d;
    mix_q    <= mix_d;
    inside_q <= inside_d;
  end

  // one lane per color channel
  dgm_blend u_red (
    .clk_i  (clk_i),
    .low_i  (low_q[23:16]),
    .high_i (high_q[23:16]),
    .mix_i  (mix_q),
    .chan_o (out_red_o)
  );

  dgm_blend u_green (
    .clk_i  (clk_i),
    .low_i  (low_q[15:8]),
    .high_i (high_q[15:8]),
    .mix_i  (mix_q),
    .chan_o (out_green_o)
  );

  dgm_blend u_blue (
    .clk_i  (clk_i),
    .low_i  (low_q[7:0]),
    .high_i (high_q[7:0]),
    .mix_i  (mix_q),
    .chan_o (out_blue_o)
  );

  // inside flag follows the two lane stages
  logic prod_vld_q, out_vld_q;
  logic inside_p_q, inside_o_q;

  always_ff @(posedge clk_i) begin
    inside_p_q <= inside_q;
    inside_o_q <= inside_p_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q   <= 1'b0;
      sel_vld_q  <= 1'b0;
      prod_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      in_vld_q   <= accept;
      sel_vld_q  <= in_vld_q;
      prod_vld_q <= sel_vld_q;
      out_vld_q  <= prod_vld_q;
    end
  end

  assign out_valid_o   = out_vld_q;
  assign inside_mask_o = inside_o_q;

endmodule

`default_nettype wire

// ===== sv/dgm_blend.sv =====
// one color channel of the gradient blend: two-stage multiply and divide by 765
// depends on dgm_pkg
`timescale 1ns / 1ps
`default_nettype none

module dgm_blend (
  input  logic                       clk_i,
  input  logic [dgm_pkg::ChanW-1:0]  low_i,
  input  logic [dgm_pkg::ChanW-1:0]  high_i,
  input  logic [dgm_pkg::SumW-1:0]   mix_i,
  output logic [dgm_pkg::ChanW-1:0]  chan_o
);
  import dgm_pkg::*;

  localparam int unsigned ProdW = NumW + DivMulW;

  logic [SumW-1:0]  mix_comp;
  logic [NumW-1:0]  num_d, num_q;
  logic [ProdW-1:0] prod;
  logic [ChanW-1:0] chan_d, chan_q;

  always_comb begin
    mix_comp = FullScale - mix_i;
    num_d    = NumW'(high_i * mix_i) + NumW'(low_i * mix_comp);
  end

  // exact floor division via reciprocal multiply
  always_comb begin
    prod   = ProdW'(num_q) * ProdW'(DivMul);
    chan_d = prod[DivShift +: ChanW];
  end

  always_ff @(posedge clk_i) begin
    num_q  <= num_d;
    chan_q <= chan_d;
  end

  assign chan_o = chan_q;

endmodule

`default_nettype wire

// ===== tb/sv/duotone_gradient_map_with_mask_unit_test.sv =====
// self-checking testbench for duotone_gradient_map_with_mask_unit
// depends on dgm_pkg and the unit; predicts each mapped pixel and checks it in order
`timescale 1ns / 1ps

module duotone_gradient_map_with_mask_unit_test;
  import dgm_pkg::*;

  localparam int unsigned StallLimit = 1000;
  localparam int unsigned TailCycles = 8;
  localparam int unsigned PhaseItems = 150;
  localparam int unsigned NumPhases  = 6;
  localparam int unsigned PixelW     = 6 * ChanW;
  // the index field is wider than the register list
  localparam logic [CfgIdxW-1:0] CfgSpareA = 3'd6;
  localparam logic [CfgIdxW-1:0] CfgSpareB = 3'd7;

  typedef struct packed {
    logic [ChanW-1:0] back_red;
    logic [ChanW-1:0] back_green;
    logic [ChanW-1:0] back_blue;
    logic [ChanW-1:0] mask_red;
    logic [ChanW-1:0] mask_green;
    logic [ChanW-1:0] mask_blue;
  } pixel_t;

  typedef struct packed {
    logic [ChanW-1:0] red;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] blue;
    logic             in_mask;
  } mapped_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                start_i = 1'b0;
  logic                busy_o;
  logic [ChanW-1:0]    back_red_i = '0;
  logic [ChanW-1:0]    back_green_i = '0;
  logic [ChanW-1:0]    back_blue_i = '0;
  logic [ChanW-1:0]    mask_red_i = '0;
  logic [ChanW-1:0]    mask_green_i = '0;
  logic [ChanW-1:0]    mask_blue_i = '0;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;
  logic                out_valid_o;
  logic [ChanW-1:0]    out_red_o;
  logic [ChanW-1:0]    out_green_o;
  logic [ChanW-1:0]    out_blue_o;
  logic                inside_mask_o;

  // local copy of the register file
  logic [ColorW-1:0] bg_low = 24'h000000;
  logic [ColorW-1:0] bg_high = 24'hFFFFFF;
  logic [ColorW-1:0] mask_low = 24'h000000;
  logic [ColorW-1:0] mask_high = 24'hFFFFFF;
  logic              inv_inside = 1'b1;
  logic [ChanW-1:0]  thresh = 8'd50;

  pixel_t  pending_pixels[$];
  mapped_t expected_pixels[$];
  int      send_idle_pct = 0;
  int      mismatch_count = 0;
  int      stall_cycles = 0;
  logic    item_taken = 1'b0;

  duotone_gradient_map_with_mask_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .busy_o        (busy_o),
    .back_red_i    (back_red_i),
    .back_green_i  (back_green_i),
    .back_blue_i   (back_blue_i),
    .mask_red_i    (mask_red_i),
    .mask_green_i  (mask_green_i),
    .mask_blue_i   (mask_blue_i),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .out_valid_o   (out_valid_o),
    .out_red_o     (out_red_o),
    .out_green_o   (out_green_o),
    .out_blue_o    (out_blue_o),
    .inside_mask_o (inside_mask_o)
  );

  always #5 clk_i = ~clk_i;

  function automatic logic [ChanW-1:0] blend(logic [ChanW-1:0] lo, logic [ChanW-1:0] hi,
                                             logic [SumW-1:0] s);
    int unsigned l, h, k, num;
    l = lo;
    h = hi;
    k = s;
    num = h * k + l * (765 - k);
    return ChanW'(num / 765);
  endfunction

  function automatic mapped_t map_pixel(pixel_t px);
    logic [SumW-1:0]   s, msum;
    logic              in_mask;
    logic [ColorW-1:0] lo, hi;
    mapped_t           m;
    s = SumW'(px.back_red) + SumW'(px.back_green) + SumW'(px.back_blue);
    msum = SumW'(px.mask_red) + SumW'(px.mask_green) + SumW'(px.mask_blue);
    // strict compare: a mask sum equal to three times the threshold is outside
    in_mask = msum > 3 * SumW'(thresh);
    lo = in_mask ? mask_low : bg_low;
    hi = in_mask ? mask_high : bg_high;
    if (in_mask && inv_inside) s = FullScale - s;
    m.red = blend(lo[23:16], hi[23:16], s);
    m.green = blend(lo[15:8], hi[15:8], s);
    m.blue = blend(lo[7:0], hi[7:0], s);
    m.in_mask = in_mask;
    return m;
  endfunction

  function automatic pixel_t make_pixel(int br, int bg, int bb, int mr, int mg, int mb);
    pixel_t px;
    px.back_red = ChanW'(br);
    px.back_green = ChanW'(bg);
    px.back_blue = ChanW'(bb);
    px.mask_red = ChanW'(mr);
    px.mask_green = ChanW'(mg);
    px.mask_blue = ChanW'(mb);
    return px;
  endfunction

  function automatic logic [ChanW-1:0] near_thresh();
    int v;
    v = int'(thresh) + int'($urandom_range(4)) - 2;
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return ChanW'(v);
  endfunction

  function automatic pixel_t random_pixel();
    pixel_t px;
    px = pixel_t'(PixelW'({$urandom, $urandom}));
    case ($urandom_range(3))
      1: begin
        px.mask_red = near_thresh();
        px.mask_green = near_thresh();
        px.mask_blue = near_thresh();
      end
      2: begin
        px.mask_red = thresh;
        px.mask_green = thresh;
        px.mask_blue = thresh;
      end
      3: begin
        // background channels each at 0 or 255
        px.back_red = $urandom_range(1) ? 8'hFF : 8'h00;
        px.back_green = $urandom_range(1) ? 8'hFF : 8'h00;
        px.back_blue = $urandom_range(1) ? 8'hFF : 8'h00;
      end
      default: ;
    endcase
    return px;
  endfunction

  function automatic logic [ColorW-1:0] random_color();
    return ColorW'($urandom_range(32'hFF_FFFF));
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch: %s got %0d expected %0d at %0t", what, got, want, $time);
    mismatch_count++;
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CfgBgLow:     bg_low = data;
      CfgBgHigh:    bg_high = data;
      CfgMaskLow:   mask_low = data;
      CfgMaskHigh:  mask_high = data;
      CfgInvert:    inv_inside = data[0];
      CfgThreshold: thresh = data[ChanW-1:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic configure_phase(input int ph);
    case (ph)
      1: begin
        // reversed gradients, no inversion, everything nonzero is inside
        write_reg(CfgBgLow, 24'hFFFFFF);
        write_reg(CfgBgHigh, 24'h000000);
        write_reg(CfgMaskLow, 24'hFFFFFF);
        write_reg(CfgMaskHigh, 24'h000000);
        write_reg(CfgInvert, 24'h000000);
        write_reg(CfgThreshold, 24'h000000);
      end
      2: begin
        // threshold at max: no mask sum can exceed it
        write_reg(CfgBgLow, random_color());
        write_reg(CfgBgHigh, random_color());
        write_reg(CfgInvert, 24'hFFFFFE);
        write_reg(CfgThreshold, 24'h0000FF);
      end
      3: begin
        write_reg(CfgBgLow, 24'h000000);
        write_reg(CfgBgHigh, 24'h000000);
        write_reg(CfgMaskLow, 24'hFFFFFF);
        write_reg(CfgMaskHigh, 24'hFFFFFF);
        write_reg(CfgInvert, 24'h000003);
        write_reg(CfgThreshold, 24'hA5C301);
        // writes to unused indexes must leave the registers alone
        write_reg(CfgSpareA, random_color());
        write_reg(CfgSpareB, random_color());
      end
      default: begin
        write_reg(CfgBgLow, random_color());
        write_reg(CfgBgHigh, random_color());
        write_reg(CfgMaskLow, random_color());
        write_reg(CfgMaskHigh, random_color());
        write_reg(CfgInvert, random_color());
        write_reg(CfgThreshold, random_color());
      end
    endcase
  endtask

  task automatic wait_drained();
    while (pending_pixels.size() != 0 || start_i || expected_pixels.size() != 0)
      @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);
  endtask

  // driver: holds an item until it is taken, then moves on or idles
  always @(negedge clk_i) begin : drive_pixels
    pixel_t px;
    if (rst_ni && (!start_i || item_taken)) begin
      if (pending_pixels.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        px = pending_pixels.pop_front();
        start_i <= 1'b1;
        back_red_i <= px.back_red;
        back_green_i <= px.back_green;
        back_blue_i <= px.back_blue;
        mask_red_i <= px.mask_red;
        mask_green_i <= px.mask_green;
        mask_blue_i <= px.mask_blue;
      end else begin
        start_i <= 1'b0;
      end
    end
  end

  // monitor: check results against the oldest prediction, then record new items
  always @(posedge clk_i) begin : check_results
    mapped_t want;
    if (rst_ni) begin
      if (out_valid_o) begin
        if (expected_pixels.size() == 0) begin
          report_mismatch("result with no item pending, red", out_red_o, 0);
        end else begin
          want = expected_pixels.pop_front();
          if (out_red_o !== want.red) report_mismatch("out_red", out_red_o, want.red);
          if (out_green_o !== want.green)
            report_mismatch("out_green", out_green_o, want.green);
          if (out_blue_o !== want.blue) report_mismatch("out_blue", out_blue_o, want.blue);
          if (inside_mask_o !== want.in_mask)
            report_mismatch("inside_mask", inside_mask_o, want.in_mask);
        end
      end
      item_taken <= start_i && !busy_o;
      if (start_i && !busy_o)
        expected_pixels.push_back(map_pixel(make_pixel(back_red_i, back_green_i,
            back_blue_i, mask_red_i, mask_green_i, mask_blue_i)));
    end
  end

  always @(posedge clk_i) begin : watchdog
    if (rst_ni) begin
      if ((start_i && !busy_o) || out_valid_o || (cfg_valid_i && cfg_ready_o))
        stall_cycles = 0;
      else
        stall_cycles++;
      if (stall_cycles >= StallLimit) begin
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  initial begin
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed pixels at the reset register values
    send_idle_pct = 29;
    pending_pixels.push_back(make_pixel(0, 0, 0, 0, 0, 0));
    pending_pixels.push_back(make_pixel(255, 255, 255, 0, 0, 0));
    pending_pixels.push_back(make_pixel(255, 255, 255, 50, 50, 50));
    pending_pixels.push_back(make_pixel(0, 0, 0, 51, 50, 50));
    pending_pixels.push_back(make_pixel(255, 255, 255, 255, 255, 255));
    pending_pixels.push_back(make_pixel(0, 0, 0, 255, 255, 255));
    pending_pixels.push_back(make_pixel(1, 0, 0, 0, 0, 151));
    pending_pixels.push_back(make_pixel(254, 255, 255, 150, 0, 0));
    pending_pixels.push_back(make_pixel(128, 64, 32, 49, 50, 51));
    pending_pixels.push_back(make_pixel(85, 85, 85, 0, 0, 0));
    pending_pixels.push_back(make_pixel(170, 170, 170, 200, 10, 0));
    pending_pixels.push_back(make_pixel(0, 255, 0, 0, 0, 150));
    pending_pixels.push_back(make_pixel(255, 0, 0, 255, 0, 0));
    pending_pixels.push_back(make_pixel(0, 0, 255, 1, 1, 1));
    pending_pixels.push_back(make_pixel(8'h55, 8'hAA, 8'h0F, 8'hAA, 8'h55, 8'hF0));
    wait_drained();

    for (int ph = 0; ph < NumPhases; ph++) begin
      configure_phase(ph);
      case (ph / 2)
        0:       send_idle_pct = 29;
        1:       send_idle_pct = 56;
        default: send_idle_pct = 0;
      endcase
      repeat (PhaseItems) pending_pixels.push_back(random_pixel());
      wait_drained();
    end

    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/dgm_pkg.sv
sv/dgm_blend.sv
sv/duotone_gradient_map_with_mask_unit.sv
tb/sv/duotone_gradient_map_with_mask_unit_test.sv
